>>> design/assert_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_CHECK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("check failed");

// The expression must never be true.
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

>>> design/u8d_pkg.sv
`default_nettype none

package u8d_pkg;

	localparam int unsigned CpW  = 21;
	localparam int unsigned CntW = 3;

	localparam logic [7:0] ContLo      = 8'h80;
	localparam logic [7:0] ContHi      = 8'hBF;
	localparam logic [7:0] BadLo       = 8'hF5;
	localparam logic [7:0] Lead4Lo     = 8'hF0;
	localparam logic [7:0] Lead3Lo     = 8'hE0;
	localparam logic [7:0] Lead4Mask   = 8'h07;
	localparam logic [7:0] Lead3Mask   = 8'h0F;
	localparam logic [7:0] Lead2Mask   = 8'h1F;
	localparam logic [7:0] ContMask    = 8'h3F;
	localparam logic [CpW-1:0] CpLimit = 21'h110000;
	localparam logic [CpW-1:0] SurLo   = 21'h00D800;
	localparam logic [CpW-1:0] SurHi   = 21'h00DFFF;

	typedef struct packed {
		logic [CpW-1:0]  code_point;
		logic            is_error;
		logic [CntW-1:0] byte_count;
		logic            last_result;
	} result_t;

	// Up to two results from one byte; num is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} pair_t;

endpackage

`default_nettype wire

>>> design/u8d_decode.sv
`default_nettype none

// Sequence state and the per-byte decision logic.
module u8d_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    data_byte,
	input  wire logic          end_of_string,
	output u8d_pkg::pair_t     pair
);

	logic [1:0]                pend_q;
	logic [2:0]                len_q;
	logic [u8d_pkg::CpW-1:0]   acc_q;
	logic                      skip_q;

	logic [1:0]                pend_d;
	logic [2:0]                len_d;
	logic [u8d_pkg::CpW-1:0]   acc_d;
	logic                      skip_d;

	// What the byte would do if no sequence were open.
	logic                      f_res;
	u8d_pkg::result_t          f_r;
	logic [1:0]                f_pend;
	logic [2:0]                f_len;
	logic [u8d_pkg::CpW-1:0]   f_acc;
	logic                      f_skip;

	logic                      is_cont;
	logic                      is_skip;
	logic [u8d_pkg::CpW-1:0]   acc_next;
	logic                      bad_value;
	logic                      r0_v;
	logic                      r1_v;
	u8d_pkg::result_t          r0;
	u8d_pkg::result_t          r1;
	u8d_pkg::result_t          err_r;

	always_comb begin
		is_cont = data_byte inside {[u8d_pkg::ContLo:u8d_pkg::ContHi]};
		is_skip = is_cont || (data_byte inside {[u8d_pkg::BadLo:8'hFF]});
		acc_next = {acc_q[u8d_pkg::CpW-7:0], data_byte[5:0]};
		bad_value = (acc_next >= u8d_pkg::CpLimit) ||
			((acc_next >= u8d_pkg::SurLo) && (acc_next <= u8d_pkg::SurHi));
		err_r = '{code_point: '0, is_error: 1'b1, byte_count: '0, last_result: 1'b0};
	end

	always_comb begin
		f_res  = 1'b1;
		f_r    = err_r;
		f_pend = 2'd0;
		f_len  = 3'd0;
		f_acc  = '0;
		f_skip = 1'b0;
		if (!data_byte[7]) begin
			f_r = '{code_point: {13'd0, data_byte}, is_error: 1'b0,
				byte_count: 3'd1, last_result: 1'b0};
		end else if (is_skip) begin
			f_skip = !end_of_string;
		end else begin
			if (data_byte >= u8d_pkg::Lead4Lo) begin
				f_acc  = {13'd0, data_byte & u8d_pkg::Lead4Mask};
				f_pend = 2'd3;
				f_len  = 3'd4;
			end else if (data_byte >= u8d_pkg::Lead3Lo) begin
				f_acc  = {13'd0, data_byte & u8d_pkg::Lead3Mask};
				f_pend = 2'd2;
				f_len  = 3'd3;
			end else begin
				f_acc  = {13'd0, data_byte & u8d_pkg::Lead2Mask};
				f_pend = 2'd1;
				f_len  = 3'd2;
			end
			// A lead byte on the last byte of a string is a truncated sequence.
			f_res = end_of_string;
		end
	end

	always_comb begin
		pend_d = pend_q;
		len_d  = len_q;
		acc_d  = acc_q;
		skip_d = skip_q;
		r0_v   = 1'b0;
		r1_v   = 1'b0;
		r0     = err_r;
		r1     = f_r;
		if (pend_q != 2'd0) begin
			if (is_cont) begin
				acc_d  = acc_next;
				pend_d = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					r0_v = 1'b1;
					if (!bad_value) begin
						r0 = '{code_point: acc_next, is_error: 1'b0,
							byte_count: len_q, last_result: 1'b0};
					end
					pend_d = 2'd0;
					len_d  = 3'd0;
					acc_d  = '0;
				end else if (end_of_string) begin
					r0_v = 1'b1;
				end
			end else begin
				// Broken sequence: report it, then decode the byte afresh.
				r0_v   = 1'b1;
				r1_v   = f_res;
				pend_d = f_pend;
				len_d  = f_len;
				acc_d  = f_acc;
				skip_d = f_skip;
			end
		end else if (skip_q && is_skip) begin
			skip_d = skip_q;
		end else begin
			r0_v   = f_res;
			r0     = f_r;
			pend_d = f_pend;
			len_d  = f_len;
			acc_d  = f_acc;
			skip_d = f_skip;
		end
		if (end_of_string) begin
			pend_d = 2'd0;
			len_d  = 3'd0;
			acc_d  = '0;
			skip_d = 1'b0;
		end
	end

	always_comb begin
		pair.num = {1'b0, r0_v} + {1'b0, r1_v};
		pair.r0  = r0_v ? r0 : r1;
		pair.r1  = r1;
		pair.r0.last_result = !(r0_v && r1_v);
		pair.r1.last_result = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			len_q  <= 3'd0;
			acc_q  <= '0;
			skip_q <= 1'b0;
		end else if (step) begin
			pend_q <= pend_d;
			len_q  <= len_d;
			acc_q  <= acc_d;
			skip_q <= skip_d;
		end
	end

`include "assert_macros.svh"

	`ASSERT_CHECK(a_len_covers_pend, (pend_q != 2'd0) |-> (len_q == ({1'b0, pend_q} + 3'd1) || len_q > {1'b0, pend_q}))
	`ASSERT_NEVER(a_skip_in_seq, skip_q && (pend_q != 2'd0))

endmodule

`default_nettype wire

>>> design/u8d_out.sv
`default_nettype none

// Result register: holds the results of one byte and hands them out one per transfer.
module u8d_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire u8d_pkg::pair_t    pair,
	output logic                   can_load,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output u8d_pkg::result_t       res
);

	logic             v0_q;
	logic             v1_q;
	u8d_pkg::result_t r0_q;
	u8d_pkg::result_t r1_q;
	logic             take;

	always_comb begin
		res_valid = v0_q || v1_q;
		res       = v0_q ? r0_q : r1_q;
		take      = res_valid && res_ready;
		// Free, or the only result left leaves in this cycle.
		can_load  = !res_valid || (take && (v0_q ^ v1_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (load) begin
			v0_q <= pair.num != 2'd0;
			v1_q <= pair.num == 2'd2;
		end else if (take) begin
			if (v0_q) begin
				v0_q <= 1'b0;
			end else begin
				v1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= pair.r0;
			r1_q <= pair.r1;
		end
	end

`include "assert_macros.svh"

	`ASSERT_CHECK(a_pair_loaded, (load && pair.num == 2'd2) |=> (v0_q && v1_q))
	`ASSERT_CHECK(a_err_zero, (res_valid && res.is_error) |-> ({res.code_point, res.byte_count} == '0))
	`ASSERT_NEVER(a_load_busy, load && res_valid && !(res_ready && (v0_q ^ v1_q)))

endmodule

`default_nettype wire

>>> design/utf8_stream_decoder.sv
// UTF-8 stream decoder. Bytes arrive one per transfer on the s_ side, with s_tlast marking the
// final byte of a string, and decoded results leave one per transfer on the m_ side. A result
// is either a Unicode scalar value with the number of bytes it used, or an error with code point
// and byte count both zero; m_tlast marks the final result caused by a given input byte. Most
// bytes give at most one result, but a byte that breaks an open sequence gives an error and is
// then decoded again, so it may give two. Overlong forms are accepted; values at or above 0x110000
// and surrogates are errors. The block sustains one byte per clock cycle while m_tready stays high
// and each byte gives at most one result; a byte that gives two results holds the input back, as
// the result register hands out one result per cycle. A byte passes through the input register
// and then the result register before its first result is offered on the m_ side.
`default_nettype none

module utf8_stream_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // end_of_string
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [20:0] code_point, [21] is_error, [24:22] byte_count
	output logic             m_tlast    // last_result
);

	// Input register: a byte waits here while the result register is still busy.
	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic             eos_s1;

	logic             advance;
	logic             can_load;
	u8d_pkg::pair_t   pair;
	u8d_pkg::result_t res;

	// The decoder state steps and the result register loads in the same cycle.
	assign advance  = vld_s1 && can_load;
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	u8d_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_byte     (byte_s1),
		.end_of_string (eos_s1),
		.pair          (pair)
	);

	u8d_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.pair      (pair),
		.can_load  (can_load),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Results are packed from the lowest bit up; the upper bits are padding.
	assign m_tdata = {7'd0, res.byte_count, res.is_error, res.code_point};
	assign m_tlast = res.last_result;

endmodule

`default_nettype wire
